// File: rtl/csv_fd_pkg.sv
package csv_fd_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int ROW_BITS_DEF    = 16;
    localparam int COLUMN_BITS_DEF = 10;

    localparam logic [7:0] DELIM_RESET = 8'd44;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_NBSP  = 8'd160;

    typedef enum logic [2:0] {
        MODE_ROW_START   = 3'd0,
        MODE_LEAD        = 3'd1,
        MODE_UNQUOTED    = 3'd2,
        MODE_QUOTED_LEAD = 3'd3,
        MODE_QUOTED_BODY = 3'd4,
        MODE_AFTER       = 3'd5,
        MODE_DONE        = 3'd6,
        MODE_ERROR       = 3'd7
    } parse_mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EOT_QUOTED = 2'd1,
        ST_BAD_CHAR   = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } in_item_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NBSP);
    endfunction

endpackage

// File: rtl/csv_field_delimiter_core.sv
// channel   | ports                       | tdata / tuser / tlast
// s (in)    | s_tvalid s_tready s_tdata   | char_in ; tlast end_of_text
// m (out)   | m_tvalid m_tready m_tdata   | row, column, start, end ; tuser status ;
//           |                             | tlast end_of_row
// cfg       | cfg_valid cfg_ready cfg_data| delimiter
//
// one item per cycle while the result side is not stalled; an input item goes
// through the input register, then parse logic into the result register
// the per-byte state update is one short combinational step per cycle
// aresetn synchronous active low: row start, all counters zero, delimiter comma
// a stalled result register holds the next item in the input register only
module csv_field_delimiter_core #(
    parameter int OFFSET_BITS = csv_fd_pkg::OFFSET_BITS_DEF,
    parameter int ROW_BITS    = csv_fd_pkg::ROW_BITS_DEF,
    parameter int COLUMN_BITS = csv_fd_pkg::COLUMN_BITS_DEF,
    localparam int FIELDS_W   = ROW_BITS + COLUMN_BITS + 2 * OFFSET_BITS,
    localparam int M_TDATA_W  = ((FIELDS_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,  // delimiter
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // char_in
    input  logic                 s_tlast,   // end_of_text
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // row_index, column_index, field_start, field_end
    output logic [1:0]           m_tuser,   // status
    output logic                 m_tlast    // end_of_row
);
    import csv_fd_pkg::*;

    logic [7:0]             delim_reg;
    logic                   in_valid;
    in_item_t               in_item;
    logic                   in_take;
    logic [ROW_BITS-1:0]    out_row;
    logic [COLUMN_BITS-1:0] out_column;
    logic [OFFSET_BITS-1:0] out_start;
    logic [OFFSET_BITS-1:0] out_end;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= DELIM_RESET;
        end else if (cfg_valid) begin
            delim_reg <= cfg_data;
        end
    end

    csv_fd_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .in_valid (in_valid),
        .in_item  (in_item),
        .in_take  (in_take)
    );

    csv_fd_parser #(
        .OFFSET_BITS (OFFSET_BITS),
        .ROW_BITS    (ROW_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .delimiter  (delim_reg),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .in_take    (in_take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_row    (out_row),
        .out_column (out_column),
        .out_start  (out_start),
        .out_end    (out_end),
        .out_eor    (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({out_end, out_start, out_column, out_row});

endmodule

// File: rtl/csv_fd_in_stage.sv
module csv_fd_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // char_in
    input  logic                 s_tlast,   // end_of_text
    output logic                 in_valid,
    output csv_fd_pkg::in_item_t in_item,
    input  logic                 in_take
);
    import csv_fd_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign s_tready = !valid_reg || in_take;
    assign in_valid = valid_reg;
    assign in_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.char_in     <= s_tdata;
            item_reg.end_of_text <= s_tlast;
        end
    end

endmodule

// File: rtl/csv_fd_parser.sv
module csv_fd_parser #(
    parameter int OFFSET_BITS = csv_fd_pkg::OFFSET_BITS_DEF,
    parameter int ROW_BITS    = csv_fd_pkg::ROW_BITS_DEF,
    parameter int COLUMN_BITS = csv_fd_pkg::COLUMN_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [7:0]              delimiter,
    input  logic                    in_valid,
    input  csv_fd_pkg::in_item_t    in_item,
    output logic                    in_take,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              out_status,
    output logic [ROW_BITS-1:0]     out_row,
    output logic [COLUMN_BITS-1:0]  out_column,
    output logic [OFFSET_BITS-1:0]  out_start,
    output logic [OFFSET_BITS-1:0]  out_end,
    output logic                    out_eor
);
    import csv_fd_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [ROW_BITS-1:0]    ROW_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

    parse_mode_t            mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] end_reg, end_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic                   pcr_reg, pcr_next;

    logic                   out_valid_reg;
    status_t                status_reg;
    logic [ROW_BITS-1:0]    orow_reg;
    logic [COLUMN_BITS-1:0] ocol_reg;
    logic [OFFSET_BITS-1:0] ostart_reg;
    logic [OFFSET_BITS-1:0] oend_reg;
    logic                   oeor_reg;

    logic                   room;
    logic                   item_go;
    logic [7:0]             b;
    logic                   eot;
    logic                   b_blank, b_nl, b_delim, b_quote;
    logic [OFFSET_BITS-1:0] q_inc;
    logic                   after_go;
    logic [OFFSET_BITS-1:0] after_start, after_end;

    logic                   emit_valid;
    status_t                emit_status;
    logic [OFFSET_BITS-1:0] emit_start, emit_end;
    logic                   emit_eor;

    assign b       = in_item.char_in;
    assign eot     = in_item.end_of_text;
    assign b_blank = is_blank(b);
    assign b_nl    = (b == CH_LF) || (b == CH_CR);
    assign b_delim = (b == delimiter);
    assign b_quote = (b == CH_QUOTE);
    assign q_inc   = (pos_reg == OFF_MAX) ? pos_reg : pos_reg + 1'b1;

    assign room    = !out_valid_reg || out_ready;
    assign in_take = in_valid && room;
    assign item_go = in_take && (mode_reg != MODE_DONE) && (mode_reg != MODE_ERROR);

    // next state
    always_comb begin
        logic lead_go;
        lead_go     = 1'b0;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        pcr_next    = pcr_reg;
        after_go    = 1'b0;
        after_start = start_reg;
        after_end   = end_reg;
        if (item_go) begin
            if (eot) begin
                unique case (mode_reg)
                    MODE_QUOTED_LEAD, MODE_QUOTED_BODY: mode_next = MODE_ERROR;
                    default:                            mode_next = MODE_DONE;
                endcase
            end else begin
                pos_next = q_inc;
                unique case (mode_reg)
                    MODE_ROW_START: begin
                        pcr_next = 1'b0;
                        if (!(pcr_reg && (b == CH_LF))) begin
                            lead_go = 1'b1;
                        end
                    end
                    MODE_LEAD: begin
                        lead_go = 1'b1;
                    end
                    MODE_UNQUOTED: begin
                        if (b_nl || b_delim) begin
                            after_go = 1'b1;
                        end else if (!b_blank) begin
                            end_next = q_inc;
                        end
                    end
                    MODE_QUOTED_LEAD: begin
                        if (b_quote) begin
                            mode_next = MODE_AFTER;
                        end else if (b_blank) begin
                            start_next = q_inc;
                            end_next   = q_inc;
                        end else begin
                            end_next  = q_inc;
                            mode_next = MODE_QUOTED_BODY;
                        end
                    end
                    MODE_QUOTED_BODY: begin
                        if (b_quote) begin
                            mode_next = MODE_AFTER;
                        end else if (!b_blank) begin
                            end_next = q_inc;
                        end
                    end
                    default: begin
                        after_go = 1'b1;
                    end
                endcase
                if (lead_go) begin
                    mode_next = MODE_LEAD;
                    if (b_blank) begin
                        mode_next = MODE_LEAD;
                    end else if (b_quote) begin
                        start_next = q_inc;
                        end_next   = q_inc;
                        mode_next  = MODE_QUOTED_LEAD;
                    end else begin
                        start_next = pos_reg;
                        end_next   = pos_reg;
                        mode_next  = MODE_UNQUOTED;
                        if (b_nl || b_delim) begin
                            after_go    = 1'b1;
                            after_start = pos_reg;
                            after_end   = pos_reg;
                        end else begin
                            end_next = q_inc;
                        end
                    end
                end
                if (after_go) begin
                    mode_next = MODE_AFTER;
                    if (b_blank) begin
                        mode_next = MODE_AFTER;
                    end else if (b_nl) begin
                        row_next  = (row_reg == ROW_MAX) ? row_reg : row_reg + 1'b1;
                        col_next  = '0;
                        pcr_next  = (b == CH_CR);
                        mode_next = MODE_ROW_START;
                    end else if (b_delim) begin
                        col_next  = (col_reg == COL_MAX) ? col_reg : col_reg + 1'b1;
                        mode_next = MODE_LEAD;
                    end else begin
                        mode_next = MODE_ERROR;
                    end
                end
            end
        end
    end

    // result item
    always_comb begin
        emit_valid  = 1'b0;
        emit_status = ST_OK;
        emit_start  = after_start;
        emit_end    = after_end;
        emit_eor    = 1'b0;
        if (item_go && eot) begin
            unique case (mode_reg)
                MODE_ROW_START: begin
                    emit_valid = 1'b0;
                end
                MODE_LEAD: begin
                    emit_valid = 1'b1;
                    emit_start = pos_reg;
                    emit_end   = pos_reg;
                    emit_eor   = 1'b1;
                end
                MODE_QUOTED_LEAD, MODE_QUOTED_BODY: begin
                    emit_valid  = 1'b1;
                    emit_status = ST_EOT_QUOTED;
                    emit_start  = pos_reg;
                    emit_end    = pos_reg;
                end
                default: begin
                    emit_valid = 1'b1;
                    emit_start = start_reg;
                    emit_end   = end_reg;
                    emit_eor   = 1'b1;
                end
            endcase
        end else if (after_go && !b_blank) begin
            emit_valid = 1'b1;
            if (b_nl) begin
                emit_eor = 1'b1;
            end else if (!b_delim) begin
                emit_status = ST_BAD_CHAR;
                emit_start  = pos_reg;
                emit_end    = pos_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_ROW_START;
            pos_reg   <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            pcr_reg   <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            pcr_reg   <= pcr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (room) begin
            out_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid) begin
            status_reg <= emit_status;
            orow_reg   <= row_reg;
            ocol_reg   <= col_reg;
            ostart_reg <= emit_start;
            oend_reg   <= emit_end;
            oeor_reg   <= emit_eor;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_row    = orow_reg;
    assign out_column = ocol_reg;
    assign out_start  = ostart_reg;
    assign out_end    = oend_reg;
    assign out_eor    = oeor_reg;

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_ERROR |=> mode_reg == MODE_ERROR)
        else $error("error mode left without reset");

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_DONE |=> mode_reg == MODE_DONE)
        else $error("done mode left without reset");

    a_bad_item_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_valid && emit_status != ST_OK) |=> mode_reg == MODE_ERROR)
        else $error("error item sent but parser not stopped");

    // end of text right after a cr leaves the flag set in done mode
    a_pending_cr_row_start: assert property (@(posedge aclk) disable iff (!aresetn)
        pcr_reg |-> (mode_reg == MODE_ROW_START || mode_reg == MODE_DONE))
        else $error("pending cr outside row start");

endmodule

// File: tb/sv/csv_field_delimiter_core_tb.sv
module csv_field_delimiter_core_tb;
    import csv_fd_pkg::*;

    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        parse_mode_t mode;
        logic [23:0] pos;
        logic [23:0] fstart;
        logic [23:0] fend;
        logic [15:0] row;
        logic [9:0]  col;
        logic        cr_seen;
        logic [7:0]  delim;
    } scan_state_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] row;
        logic [9:0]  col;
        logic [23:0] fstart;
        logic [23:0] fend;
        logic        eor;
    } field_rec_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // char_in
    logic        s_tlast = 1'b0;    // end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;           // row_index, column_index, field_start, field_end
    logic [1:0]  m_tuser;           // status
    logic        m_tlast;           // end_of_row

    scan_state_t scan;
    field_rec_t  expected_fields[$];
    int unsigned text_items = 0;
    int unsigned fields_checked = 0;
    int unsigned delim_writes = 0;
    int unsigned fail_count = 0;
    int unsigned end_kind = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    bit          hold_off_request = 1'b0;

    csv_field_delimiter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit blank_byte(input logic [7:0] ch);
        return ch == CH_SPACE || ch == CH_TAB || ch == CH_NBSP;
    endfunction

    function automatic logic [23:0] bump_offset(input logic [23:0] v);
        return (v == 24'hFFFFFF) ? v : v + 24'd1;
    endfunction

    // one text byte or end of text through the tokenizer state
    function automatic bit scan_byte(input scan_state_t cur, input logic [7:0] ch,
                                     input logic eot, output scan_state_t nxt,
                                     output field_rec_t rec);
        scan_state_t s;
        logic [23:0] q;
        bit          emitted;
        bit          to_lead;
        bit          to_unq;
        bit          to_after;
        s = cur;
        q = cur.pos;
        emitted = 1'b0;
        to_lead = 1'b0;
        to_unq = 1'b0;
        to_after = 1'b0;
        rec = '0;
        rec.status = ST_OK;
        rec.row = cur.row;
        rec.col = cur.col;
        nxt = cur;
        if (cur.mode == MODE_DONE || cur.mode == MODE_ERROR)
            return 1'b0;
        if (eot) begin
            emitted = 1'b1;
            s.mode = MODE_DONE;
            case (cur.mode)
                MODE_ROW_START: emitted = 1'b0;
                MODE_LEAD: begin
                    rec.fstart = q;
                    rec.fend = q;
                    rec.eor = 1'b1;
                end
                MODE_QUOTED_LEAD, MODE_QUOTED_BODY: begin
                    s.mode = MODE_ERROR;
                    rec.status = ST_EOT_QUOTED;
                    rec.fstart = q;
                    rec.fend = q;
                end
                default: begin
                    rec.fstart = cur.fstart;
                    rec.fend = cur.fend;
                    rec.eor = 1'b1;
                end
            endcase
            nxt = s;
            return emitted;
        end
        case (cur.mode)
            MODE_ROW_START: begin
                if (!(cur.cr_seen && ch == CH_LF))
                    to_lead = 1'b1;
                s.cr_seen = 1'b0;
            end
            MODE_LEAD: to_lead = 1'b1;
            MODE_UNQUOTED: to_unq = 1'b1;
            MODE_QUOTED_LEAD: begin
                if (ch == CH_QUOTE) begin
                    s.mode = MODE_AFTER;
                end else if (blank_byte(ch)) begin
                    s.fstart = bump_offset(q);
                    s.fend = s.fstart;
                end else begin
                    s.fend = bump_offset(q);
                    s.mode = MODE_QUOTED_BODY;
                end
            end
            MODE_QUOTED_BODY: begin
                if (ch == CH_QUOTE)
                    s.mode = MODE_AFTER;
                else if (!blank_byte(ch))
                    s.fend = bump_offset(q);
            end
            default: to_after = 1'b1;
        endcase
        if (to_lead) begin
            s.mode = MODE_LEAD;
            if (ch == CH_QUOTE && !blank_byte(ch)) begin
                s.fstart = bump_offset(q);
                s.fend = s.fstart;
                s.mode = MODE_QUOTED_LEAD;
            end else if (!blank_byte(ch)) begin
                s.fstart = q;
                s.fend = q;
                s.mode = MODE_UNQUOTED;
                to_unq = 1'b1;
            end
        end
        if (to_unq) begin
            if (ch == CH_LF || ch == CH_CR || ch == s.delim)
                to_after = 1'b1;
            else if (!blank_byte(ch))
                s.fend = bump_offset(q);
        end
        if (to_after) begin
            s.mode = MODE_AFTER;
            if (blank_byte(ch)) begin
            end else if (ch == CH_LF || ch == CH_CR) begin
                emitted = 1'b1;
                rec.fstart = s.fstart;
                rec.fend = s.fend;
                rec.eor = 1'b1;
                s.row = (s.row == 16'hFFFF) ? s.row : s.row + 16'd1;
                s.col = '0;
                s.cr_seen = (ch == CH_CR);
                s.mode = MODE_ROW_START;
            end else if (ch == s.delim) begin
                emitted = 1'b1;
                rec.fstart = s.fstart;
                rec.fend = s.fend;
                s.col = (s.col == 10'h3FF) ? s.col : s.col + 10'd1;
                s.mode = MODE_LEAD;
            end else begin
                emitted = 1'b1;
                rec.status = ST_BAD_CHAR;
                rec.fstart = q;
                rec.fend = q;
                s.mode = MODE_ERROR;
            end
        end
        s.pos = bump_offset(q);
        nxt = s;
        return emitted;
    endfunction

    always @(posedge aclk) begin : check_result
        field_rec_t got;
        field_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tuser);
            got.row = m_tdata[15:0];
            got.col = m_tdata[25:16];
            got.fstart = m_tdata[49:26];
            got.fend = m_tdata[73:50];
            got.eor = m_tlast;
            fields_checked++;
            if (expected_fields.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected field: status %0d row %0d col %0d start %0d end %0d eor %0d",
                             got.status, got.row, got.col, got.fstart, got.fend, got.eor);
            end else begin
                want = expected_fields.pop_front();
                if (got.status !== want.status || got.row !== want.row ||
                    got.col !== want.col || got.fstart !== want.fstart ||
                    got.fend !== want.fend || got.eor !== want.eor) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("field %0d expected: status %0d row %0d col %0d start %0d end %0d eor %0d",
                                 fields_checked, want.status, want.row, want.col,
                                 want.fstart, want.fend, want.eor);
                        $display("field %0d actual:   status %0d row %0d col %0d start %0d end %0d eor %0d",
                                 fields_checked, got.status, got.row, got.col,
                                 got.fstart, got.fend, got.eor);
                    end
                end
            end
        end
    end

    initial begin : field_sink
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_off_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_request = 1'b0;
            end else if (rx_idle_en) begin
                gap = $urandom_range(0, 5);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    task automatic push_item(input logic [7:0] ch, input logic eot);
        int          gap;
        field_rec_t  rec;
        scan_state_t upd;
        gap = tx_idle_en ? $urandom_range(0, 5) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (scan_byte(scan, ch, eot, upd, rec))
            expected_fields.push_back(rec);
        scan = upd;
        text_items++;
    endtask

    // a byte that would end the text early with an error becomes a line feed
    task automatic send_text(input logic [7:0] ch);
        field_rec_t  rec;
        scan_state_t upd;
        if (scan_byte(scan, ch, 1'b0, upd, rec) && rec.status != ST_OK)
            ch = CH_LF;
        push_item(ch, 1'b0);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        while (expected_fields.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    task automatic set_delimiter(input logic [7:0] d);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        scan.delim = d;
        delim_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 2))
            0: return CH_SPACE;
            1: return CH_TAB;
            default: return CH_NBSP;
        endcase
    endfunction

    function automatic logic [7:0] random_text_byte();
        logic [7:0] ch;
        case ($urandom_range(0, 9))
            0: ch = CH_CR;
            1: ch = CH_LF;
            2: ch = scan.delim;
            3: ch = random_blank();
            4: ch = 8'h00;
            5: ch = 8'hFF;
            default: ch = 8'($urandom_range(0, 255));
        endcase
        return ch;
    endfunction

    task automatic send_row();
        int         nfields;
        int         shape;
        int         k;
        int         j;
        int         n;
        logic [7:0] ch;
        nfields = blank_byte(scan.delim) ? 1 : $urandom_range(0, 4);
        for (k = 0; k < nfields; k++) begin
            if (k > 0)
                send_text(scan.delim);
            repeat ($urandom_range(0, 2)) send_text(random_blank());
            shape = $urandom_range(0, 3);
            n = $urandom_range(1, 6);
            if (shape == 1) begin
                send_text(CH_QUOTE);
                for (j = 1; j < n; j++) begin
                    ch = random_text_byte();
                    send_text(ch == CH_QUOTE ? CH_SPACE : ch);
                end
                send_text(CH_QUOTE);
            end else if (shape != 0) begin
                for (j = 0; j < n; j++) begin
                    ch = random_text_byte();
                    if (ch == CH_CR || ch == CH_LF || ch == CH_QUOTE || ch == scan.delim)
                        ch = 8'(8'h61 + j);
                    send_text(ch);
                end
            end
            repeat ($urandom_range(0, 2)) send_text(random_blank());
        end
        case ($urandom_range(0, 2))
            0: send_text(CH_LF);
            1: send_text(CH_CR);
            default: begin
                send_text(CH_CR);
                send_text(CH_LF);
            end
        endcase
    endtask

    // blanks around and inside fields, quoted content with separators,
    // empty fields, byte zero and 255, cr lf pair, empty lines
    task automatic test_directed_text();
        send_text(CH_SPACE);
        send_text("a");
        send_text(CH_NBSP);
        send_text("b");
        send_text(CH_TAB);
        send_text(",");
        send_text(CH_QUOTE);
        send_text(CH_SPACE);
        send_text(",");
        send_text(CH_LF);
        send_text(CH_QUOTE);
        send_text(CH_SPACE);
        send_text(",");
        send_text(",");
        send_text(8'h00);
        send_text(8'hFF);
        send_text(CH_CR);
        send_text(CH_LF);
        send_text(CH_LF);
        send_text(CH_CR);
        send_text(CH_QUOTE);
        send_text(CH_QUOTE);
        send_text(CH_LF);
    endtask

    task automatic test_delimiter_settings();
        logic [7:0] delims[10];
        int         i;
        delims = '{8'd0, 8'd255, 8'd59, CH_TAB, CH_SPACE, CH_NBSP, CH_LF, CH_CR,
                   CH_QUOTE, 8'd124};
        for (i = 0; i < 10; i++) begin
            set_delimiter(delims[i]);
            repeat (3) send_row();
        end
    endtask

    task automatic test_random_text();
        int unsigned stop_at;
        int unsigned chunk_end;
        int          phase;
        logic [7:0]  ch;
        stop_at = text_items + 850;
        phase = 0;
        while (text_items < stop_at) begin
            case ($urandom_range(0, 7))
                0, 1, 2: set_delimiter(DELIM_RESET);
                3: set_delimiter(8'd59);
                4: set_delimiter(8'd124);
                5: set_delimiter(CH_TAB);
                6: set_delimiter(CH_QUOTE);
                default: set_delimiter(8'($urandom_range(0, 255)));
            endcase
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            if (phase == 3) begin
                tx_idle_en = 1'b0;
                hold_off_request = 1'b1;
            end
            chunk_end = text_items + 125;
            while (text_items < chunk_end) begin
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 8)) begin
                        ch = 8'($urandom_range(0, 255));
                        send_text(ch);
                    end
                end else begin
                    send_row();
                end
            end
            phase++;
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // one way of closing the text, then items the block must drop
    task automatic test_end_of_text();
        logic [7:0] ch;
        end_kind = $urandom_range(0, 5);
        case (end_kind)
            0: send_text(CH_LF);
            1: begin
                send_text("x");
                send_text(",");
                send_text(CH_SPACE);
            end
            2: begin
                send_text("x");
                send_text("y");
                send_text(CH_SPACE);
            end
            3: begin
                send_text(CH_QUOTE);
                send_text("z");
            end
            4: begin
                send_text(CH_QUOTE);
                send_text("z");
                send_text(CH_QUOTE);
                send_text(CH_SPACE);
                push_item("q", 1'b0);
            end
            default: begin
                send_text(CH_QUOTE);
                send_text("z");
                send_text(CH_QUOTE);
            end
        endcase
        if (end_kind != 4)
            push_item(8'h00, 1'b1);
        repeat (8) begin
            ch = 8'($urandom_range(0, 255));
            push_item(ch, 1'($urandom_range(0, 1)));
        end
        push_item(CH_LF, 1'b1);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    initial begin
        scan = '0;
        scan.mode = MODE_ROW_START;
        scan.delim = DELIM_RESET;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_text();
        test_delimiter_settings();
        test_random_text();
        test_end_of_text();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (expected_fields.size() != 0) begin
            fail_count += expected_fields.size();
            $display("%0d expected fields never arrived", expected_fields.size());
        end
        $display("%0d text items, %0d fields checked, %0d delimiter writes", text_items,
                 fields_checked, delim_writes);
        $display("random stalls on both sides and one long receiver hold-off, text closed by end case %0d",
                 end_kind);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
